### hdl/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;

    localparam int unsigned WORD_BITS_DEF = 32;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [1:0] {
        UOP_GCD,
        UOP_DIVG,
        UOP_MUL
    } t_unit_op;

    typedef enum logic [2:0] {
        U_IDLE,
        U_GCD,
        U_DIV,
        U_DFIN,
        U_MUL,
        U_MFIN,
        U_DONE
    } t_unit_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_NCHK,
        S_NGCD,
        S_NDIVN,
        S_NDIVD,
        S_AGCD,
        S_ADIVX,
        S_ADIVY,
        S_AMUL1,
        S_AMUL2,
        S_AADD,
        S_AMULD,
        S_MGCD1,
        S_MGCD2,
        S_MDIV1,
        S_MDIV2,
        S_MMULN,
        S_MDIV3,
        S_MDIV4,
        S_MMULD,
        S_OUT
    } t_seq_state;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    typedef struct packed {
        logic done;
        logic ov;
    } t_unit_sts;

endpackage

### hdl/rau_unit.sv
// Shared iterative unit: binary gcd, exact signed division and checked multiply.
module rau_unit #(
    parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rau_pkg::t_unit_ctl     i_ctl,
    input  logic [WORD_BITS-1:0]   i_a,
    input  logic [WORD_BITS-1:0]   i_b,
    output rau_pkg::t_unit_sts     o_sts,
    output logic [WORD_BITS-1:0]   o_res
);
    import rau_pkg::*;

    localparam int unsigned KW = $clog2(WORD_BITS);
    localparam int unsigned CW = $clog2(WORD_BITS + 1);
    localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    t_unit_state                r_state, n_state;
    logic [WORD_BITS-1:0]       r_ua, n_ua, r_ub, n_ub, r_rem, n_rem, r_res, n_res;
    logic [2*WORD_BITS-1:0]     r_acc, n_acc;
    logic [KW-1:0]              r_k, n_k;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic                       r_neg, n_neg, r_ov, n_ov;
    logic [WORD_BITS:0]         w_rem_sh;
    logic [WORD_BITS:0]         w_sum;
    logic [WORD_BITS-1:0]       w_limit;

    function automatic logic [WORD_BITS-1:0] f_mag(input logic [WORD_BITS-1:0] x);
        return x[WORD_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_ctl.start) begin
                    case (i_ctl.op)
                        UOP_GCD:  n_state = U_GCD;
                        UOP_DIVG: n_state = (i_b == '0) ? U_DONE : U_DIV;
                        UOP_MUL:  n_state = U_MUL;
                        default:  n_state = U_IDLE;
                    endcase
                end
            end
            U_GCD: begin
                if (r_ua == '0 || r_ub == '0) n_state = U_DONE;
            end
            U_DIV: begin
                if (r_cnt == CW'(WORD_BITS - 1)) n_state = U_DFIN;
            end
            U_MUL: begin
                if (r_cnt == CW'(WORD_BITS - 1)) n_state = U_MFIN;
            end
            U_DFIN:  n_state = U_DONE;
            U_MFIN:  n_state = U_DONE;
            U_DONE:  n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_comb begin
        n_ua  = r_ua;
        n_ub  = r_ub;
        n_rem = r_rem;
        n_res = r_res;
        n_acc = r_acc;
        n_k   = r_k;
        n_cnt = r_cnt;
        n_neg = r_neg;
        n_ov  = r_ov;
        w_rem_sh = {r_rem, r_ua[WORD_BITS-1]};
        w_sum = {1'b0, r_acc[2*WORD_BITS-1:WORD_BITS]} + {1'b0, (r_ub[0] ? r_ua : '0)};
        w_limit = r_neg ? WMIN : (WMIN - 1'b1);
        case (r_state)
            U_IDLE: begin
                if (i_ctl.start) begin
                    n_ov  = 1'b0;
                    n_k   = '0;
                    n_cnt = '0;
                    n_rem = '0;
                    n_acc = '0;
                    n_ua  = f_mag(i_a);
                    n_ub  = (i_ctl.op == UOP_DIVG) ? i_b : f_mag(i_b);
                    n_neg = (i_ctl.op == UOP_MUL) ? (i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1])
                                                  : i_a[WORD_BITS-1];
                    n_res = i_a;
                end
            end
            U_GCD: begin
                if (r_ua == '0) begin
                    n_res = r_ub << r_k;
                end else if (r_ub == '0) begin
                    n_res = r_ua << r_k;
                end else if (!r_ua[0] && !r_ub[0]) begin
                    n_ua = r_ua >> 1;
                    n_ub = r_ub >> 1;
                    n_k  = r_k + 1'b1;
                end else if (!r_ua[0]) begin
                    n_ua = r_ua >> 1;
                end else if (!r_ub[0]) begin
                    n_ub = r_ub >> 1;
                end else if (r_ua >= r_ub) begin
                    n_ua = r_ua - r_ub;
                end else begin
                    n_ub = r_ub - r_ua;
                end
            end
            U_DIV: begin
                if (w_rem_sh >= {1'b0, r_ub}) begin
                    n_rem = WORD_BITS'(w_rem_sh - {1'b0, r_ub});
                    n_ua  = {r_ua[WORD_BITS-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[WORD_BITS-1:0];
                    n_ua  = {r_ua[WORD_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
            end
            U_DFIN: begin
                n_res = r_neg ? (~r_ua + 1'b1) : r_ua;
            end
            U_MUL: begin
                n_acc = {w_sum, r_acc[WORD_BITS-1:1]};
                n_ub  = r_ub >> 1;
                n_cnt = r_cnt + 1'b1;
            end
            U_MFIN: begin
                n_ov  = (r_acc[2*WORD_BITS-1:WORD_BITS] != '0) ||
                        (r_acc[WORD_BITS-1:0] > w_limit);
                n_res = r_neg ? (~r_acc[WORD_BITS-1:0] + 1'b1) : r_acc[WORD_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_ua  <= n_ua;
        r_ub  <= n_ub;
        r_rem <= n_rem;
        r_res <= n_res;
        r_acc <= n_acc;
        r_k   <= n_k;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_ov  <= n_ov;
    end

    assign o_sts.done = (r_state == U_DONE);
    assign o_sts.ov   = r_ov;
    assign o_res      = r_res;

endmodule

### hdl/rational_arithmetic_unit.sv
// Rational arithmetic top level: fraction add, subtract, multiply, divide with reduction.
// Latency is data dependent: the gcd steps, exact divisions and checked multiplies of an item
// all run in turn on one shared unit.
// A zero denominator skips the unit and goes from the start state straight to the output.
// One item is in work at a time; the next is taken once the result has been delivered.
// Reset is synchronous and active low; it returns both sequencers to idle.
module rational_arithmetic_unit #(
    parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den, zero pad
    input  logic [1:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // res_num, res_den, zero pad
    output logic [1:0]   m_axis_tuser   // status
);
    import rau_pkg::*;

    localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    t_seq_state           r_state, n_state;
    logic [1:0]           r_op, n_op;
    logic [WORD_BITS-1:0] r_xn, n_xn, r_xd, n_xd, r_yn, n_yn, r_yd, n_yd;
    logic [WORD_BITS-1:0] r_n, n_n, r_d, n_d, r_t0, n_t0, r_t1, n_t1;
    logic [WORD_BITS-1:0] r_g1, n_g1, r_g2, n_g2;
    logic                 r_ov, n_ov, r_post, n_post, r_launched, n_launched;
    logic [31:0]          r_res_num, n_res_num;
    logic [30:0]          r_res_den, n_res_den;
    logic [1:0]           r_status, n_status;
    logic                 w_in_acc;
    logic                 w_unit_state;
    logic [WORD_BITS-1:0] w_sum;
    logic [WORD_BITS-1:0] u_a, u_b, u_res;
    t_unit_ctl            u_ctl;
    t_unit_sts            u_sts;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_unit_state = r_state inside {S_NGCD, S_NDIVN, S_NDIVD, S_AGCD, S_ADIVX, S_ADIVY,
                                          S_AMUL1, S_AMUL2, S_AMULD, S_MGCD1, S_MGCD2,
                                          S_MDIV1, S_MDIV2, S_MMULN, S_MDIV3, S_MDIV4,
                                          S_MMULD};
    assign w_sum = r_g2 + r_n;

    rau_unit #(
        .WORD_BITS(WORD_BITS)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (u_ctl),
        .i_a     (u_a),
        .i_b     (u_b),
        .o_sts   (u_sts),
        .o_res   (u_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_START;
            end
            S_START: begin
                if (r_xd == '0 || r_yd == '0) begin
                    n_state = S_OUT;
                end else begin
                    case (r_op)
                        OP_ADD:  n_state = S_AGCD;
                        OP_SUB:  n_state = S_NCHK;
                        OP_MUL:  n_state = S_MGCD1;
                        OP_DIV:  n_state = (r_yn == '0) ? S_OUT : S_NCHK;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_NCHK:  n_state = (r_d == '0) ? S_OUT : S_NGCD;
            S_NGCD:  if (u_sts.done) n_state = S_NDIVN;
            S_NDIVN: if (u_sts.done) n_state = S_NDIVD;
            S_NDIVD: begin
                if (u_sts.done) begin
                    if (r_post) n_state = S_OUT;
                    else n_state = (r_op == OP_SUB) ? S_AGCD : S_MGCD1;
                end
            end
            S_AGCD:  if (u_sts.done) n_state = S_ADIVX;
            S_ADIVX: if (u_sts.done) n_state = S_ADIVY;
            S_ADIVY: if (u_sts.done) n_state = S_AMUL1;
            S_AMUL1: if (u_sts.done) n_state = S_AMUL2;
            S_AMUL2: if (u_sts.done) n_state = S_AADD;
            S_AADD:  n_state = S_AMULD;
            S_AMULD: if (u_sts.done) n_state = S_NCHK;
            S_MGCD1: if (u_sts.done) n_state = S_MGCD2;
            S_MGCD2: if (u_sts.done) n_state = S_MDIV1;
            S_MDIV1: if (u_sts.done) n_state = S_MDIV2;
            S_MDIV2: if (u_sts.done) n_state = S_MMULN;
            S_MMULN: if (u_sts.done) n_state = S_MDIV3;
            S_MDIV3: if (u_sts.done) n_state = S_MDIV4;
            S_MDIV4: if (u_sts.done) n_state = S_MMULD;
            S_MMULD: if (u_sts.done) n_state = S_NCHK;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        u_ctl.start = w_unit_state && !r_launched;
        u_ctl.op    = UOP_GCD;
        u_a         = r_n;
        u_b         = r_d;
        case (r_state)
            S_NGCD:  begin u_ctl.op = UOP_GCD;  u_a = r_n;  u_b = r_d;  end
            S_NDIVN: begin u_ctl.op = UOP_DIVG; u_a = r_n;  u_b = r_g1; end
            S_NDIVD: begin u_ctl.op = UOP_DIVG; u_a = r_d;  u_b = r_g1; end
            S_AGCD:  begin u_ctl.op = UOP_GCD;  u_a = r_xd; u_b = r_yd; end
            S_ADIVX: begin u_ctl.op = UOP_DIVG; u_a = r_xd; u_b = r_g1; end
            S_ADIVY: begin u_ctl.op = UOP_DIVG; u_a = r_yd; u_b = r_g1; end
            S_AMUL1: begin u_ctl.op = UOP_MUL;  u_a = r_xn; u_b = r_t1; end
            S_AMUL2: begin u_ctl.op = UOP_MUL;  u_a = r_yn; u_b = r_t0; end
            S_AMULD: begin u_ctl.op = UOP_MUL;  u_a = r_t0; u_b = r_yd; end
            S_MGCD1: begin u_ctl.op = UOP_GCD;  u_a = r_xd; u_b = r_yn; end
            S_MGCD2: begin u_ctl.op = UOP_GCD;  u_a = r_yd; u_b = r_xn; end
            S_MDIV1: begin u_ctl.op = UOP_DIVG; u_a = r_xn; u_b = r_g2; end
            S_MDIV2: begin u_ctl.op = UOP_DIVG; u_a = r_yn; u_b = r_g1; end
            S_MMULN: begin u_ctl.op = UOP_MUL;  u_a = r_t0; u_b = r_t1; end
            S_MDIV3: begin u_ctl.op = UOP_DIVG; u_a = r_xd; u_b = r_g1; end
            S_MDIV4: begin u_ctl.op = UOP_DIVG; u_a = r_yd; u_b = r_g2; end
            S_MMULD: begin u_ctl.op = UOP_MUL;  u_a = r_t0; u_b = r_t1; end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_op = r_op;
        n_xn = r_xn;
        n_xd = r_xd;
        n_yn = r_yn;
        n_yd = r_yd;
        n_n  = r_n;
        n_d  = r_d;
        n_t0 = r_t0;
        n_t1 = r_t1;
        n_g1 = r_g1;
        n_g2 = r_g2;
        n_ov = r_ov;
        n_post = r_post;
        n_launched = r_launched;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_status  = r_status;
        if (u_ctl.start) n_launched = 1'b1;
        if (w_unit_state && u_sts.done) begin
            n_launched = 1'b0;
            n_ov = r_ov | u_sts.ov;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op   = s_axis_tuser;
                    n_xn   = WORD_BITS'($signed(s_axis_tdata[31:0]));
                    n_xd   = WORD_BITS'(s_axis_tdata[62:32]);
                    n_yn   = WORD_BITS'($signed(s_axis_tdata[94:63]));
                    n_yd   = WORD_BITS'(s_axis_tdata[125:95]);
                    n_ov   = 1'b0;
                    n_post = 1'b0;
                    n_launched = 1'b0;
                end
            end
            S_START: begin
                if (r_xd == '0 || r_yd == '0 || (r_op == OP_DIV && r_yn == '0)) begin
                    n_res_num = '0;
                    n_res_den = '0;
                    n_status  = ST_ZERO;
                end else if (r_op == OP_SUB) begin
                    n_n  = r_yn;
                    n_d  = ~r_yd + 1'b1;
                    n_ov = r_ov | (r_yd == WMIN);
                end else begin
                    n_n = r_yd;
                    n_d = r_yn;
                end
            end
            S_NCHK: begin
                if (r_d == '0) begin
                    n_res_num = '0;
                    n_res_den = '0;
                    n_status  = ST_ZERO;
                end else if (r_d[WORD_BITS-1]) begin
                    n_d  = ~r_d + 1'b1;
                    n_n  = ~r_n + 1'b1;
                    n_ov = r_ov | (r_d == WMIN) | (r_n == WMIN);
                end
            end
            S_NGCD:  if (u_sts.done) n_g1 = u_res;
            S_NDIVN: if (u_sts.done) n_n = u_res;
            S_NDIVD: begin
                if (u_sts.done) begin
                    n_d = u_res;
                    if (r_post) begin
                        n_res_num = 32'($signed(r_n));
                        n_res_den = 31'($signed(u_res));
                        n_status  = (r_ov | u_sts.ov) ? ST_OVF : ST_OK;
                    end else begin
                        n_yn = r_n;
                        n_yd = u_res;
                    end
                end
            end
            S_AGCD:  if (u_sts.done) n_g1 = u_res;
            S_ADIVX: if (u_sts.done) n_t0 = u_res;
            S_ADIVY: if (u_sts.done) n_t1 = u_res;
            S_AMUL1: if (u_sts.done) n_g2 = u_res;
            S_AMUL2: if (u_sts.done) n_n = u_res;
            S_AADD: begin
                n_n = w_sum;
                if (r_g2[WORD_BITS-1] == r_n[WORD_BITS-1] &&
                    w_sum[WORD_BITS-1] != r_g2[WORD_BITS-1]) begin
                    n_ov = 1'b1;
                end
            end
            S_AMULD: begin
                if (u_sts.done) begin
                    n_d    = u_res;
                    n_post = 1'b1;
                end
            end
            S_MGCD1: if (u_sts.done) n_g1 = u_res;
            S_MGCD2: if (u_sts.done) n_g2 = u_res;
            S_MDIV1: if (u_sts.done) n_t0 = u_res;
            S_MDIV2: if (u_sts.done) n_t1 = u_res;
            S_MMULN: if (u_sts.done) n_n = u_res;
            S_MDIV3: if (u_sts.done) n_t0 = u_res;
            S_MDIV4: if (u_sts.done) n_t1 = u_res;
            S_MMULD: begin
                if (u_sts.done) begin
                    n_d    = u_res;
                    n_post = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
        end
        r_op      <= n_op;
        r_xn      <= n_xn;
        r_xd      <= n_xd;
        r_yn      <= n_yn;
        r_yd      <= n_yd;
        r_n       <= n_n;
        r_d       <= n_d;
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_g1      <= n_g1;
        r_g2      <= n_g2;
        r_ov      <= n_ov;
        r_post    <= n_post;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_status  <= n_status;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_res_den, r_res_num};
    assign m_axis_tuser  = r_status;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the rational arithmetic unit: random and corner fractions.
`timescale 1ns / 100ps

module tb_top;
    import rau_pkg::*;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] a_num;
        logic [30:0] a_den;
        logic [31:0] b_num;
        logic [30:0] b_den;
    } t_frac_req;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic [1:0]  status;
    } t_frac_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    t_frac_req pending_q[$];
    t_frac_res result_q[$];
    int        send_gap;
    int        recv_gap;
    int        hold_cycles;
    int        n_sent;
    int        n_recv;
    int        n_err;
    int        n_ovf;
    int        n_zero;
    bit        stim_done;

    rational_arithmetic_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Word arithmetic on 64-bit carriers holding sign-extended 32-bit values.
    function automatic logic [63:0] wrap32(logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [63:0] chk_add(logic [63:0] a, logic [63:0] b, ref bit ov);
        logic [63:0] s;
        s = wrap32(a + b);
        if (a[63] == b[63] && s[63] != a[63]) ov = 1;
        return s;
    endfunction

    function automatic logic [63:0] chk_neg(logic [63:0] a, ref bit ov);
        logic [63:0] r;
        r = wrap32(64'd0 - a);
        if (a[63] && r[63]) ov = 1;
        return r;
    endfunction

    function automatic logic [63:0] chk_mul(logic [63:0] a, logic [63:0] b, ref bit ov);
        logic [63:0] ua, ub, lim;
        ua = abs64(a);
        ub = abs64(b);
        lim = (a[63] != b[63]) ? 64'h8000_0000 : 64'h7fff_ffff;
        if (ub != 0 && ua > lim / ub) ov = 1;
        return wrap32(a * b);
    endfunction

    function automatic logic [63:0] div_exact(logic [63:0] x, logic [63:0] g);
        logic [63:0] q;
        if (g == 0) return x;
        q = abs64(x) / g;
        return wrap32(x[63] ? 64'd0 - q : q);
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic bit reduce(logic [63:0] n, logic [63:0] d, ref logic [63:0] rn,
                                  ref logic [63:0] rd, ref bit ov);
        logic [63:0] g;
        if (d == 0) return 0;
        if (d[63]) begin
            d = chk_neg(d, ov);
            n = chk_neg(n, ov);
        end
        g = gcd64(abs64(n), abs64(d));
        rn = div_exact(n, g);
        rd = div_exact(d, g);
        return 1;
    endfunction

    function automatic bit frac_sum(logic [63:0] xn, logic [63:0] xd, logic [63:0] yn,
                                    logic [63:0] yd, ref logic [63:0] rn,
                                    ref logic [63:0] rd, ref bit ov);
        logic [63:0] g, xs, ys, n, d, p1, p2;
        g = gcd64(abs64(xd), abs64(yd));
        xs = div_exact(xd, g);
        ys = div_exact(yd, g);
        p1 = chk_mul(xn, ys, ov);
        p2 = chk_mul(yn, xs, ov);
        n = chk_add(p1, p2, ov);
        d = chk_mul(xs, yd, ov);
        return reduce(n, d, rn, rd, ov);
    endfunction

    function automatic bit frac_prod(logic [63:0] xn, logic [63:0] xd, logic [63:0] yn,
                                     logic [63:0] yd, ref logic [63:0] rn,
                                     ref logic [63:0] rd, ref bit ov);
        logic [63:0] g1, g2, n, d;
        g1 = gcd64(abs64(xd), abs64(yn));
        g2 = gcd64(abs64(yd), abs64(xn));
        n = chk_mul(div_exact(xn, g2), div_exact(yn, g1), ov);
        d = chk_mul(div_exact(xd, g1), div_exact(yd, g2), ov);
        return reduce(n, d, rn, rd, ov);
    endfunction

    function automatic t_frac_res predict_fraction(t_frac_req r);
        logic [63:0] an, ad, bn, bd, rn, rd, tn, td, nd;
        bit ov, ok;
        t_frac_res res;
        ov = 0;
        rn = 0;
        rd = 0;
        tn = 0;
        td = 0;
        an = {{32{r.a_num[31]}}, r.a_num};
        bn = {{32{r.b_num[31]}}, r.b_num};
        ad = wrap32({33'd0, r.a_den});
        bd = wrap32({33'd0, r.b_den});
        if (ad == 0 || bd == 0) begin
            ok = 0;
        end else if (r.opcode == OP_ADD) begin
            ok = frac_sum(an, ad, bn, bd, rn, rd, ov);
        end else if (r.opcode == OP_SUB) begin
            nd = chk_neg(bd, ov);
            ok = reduce(bn, nd, tn, td, ov);
            if (ok) ok = frac_sum(an, ad, tn, td, rn, rd, ov);
        end else if (r.opcode == OP_MUL) begin
            ok = frac_prod(an, ad, bn, bd, rn, rd, ov);
        end else if (bn == 0) begin
            ok = 0;
        end else begin
            ok = reduce(bd, bn, tn, td, ov);
            if (ok) ok = frac_prod(an, ad, tn, td, rn, rd, ov);
        end
        if (!ok) begin
            res = '{res_num: '0, res_den: '0, status: ST_ZERO};
        end else begin
            res.res_num = rn[31:0];
            res.res_den = rd[30:0];
            res.status = ov ? ST_OVF : ST_OK;
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_num();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40) - 20;
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return $urandom_range(0, 131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(1, 24));
            1: return 31'($urandom_range(1, 3000));
            2: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd1;
            3: return 31'($urandom_range(1, 65536));
            4: return ($urandom_range(0, 19) == 0) ? 31'd0 : 31'($urandom_range(1, 720));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic add_item(logic [1:0] op, logic [31:0] an, logic [30:0] ad,
                            logic [31:0] bn, logic [30:0] bd);
        pending_q.push_back('{opcode: op, a_num: an, a_den: ad, b_num: bn, b_den: bd});
    endtask

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [1:0] op;
        stim_done = 0;
        add_item(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
        add_item(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
        add_item(OP_MUL, 32'hffff_fffe, 31'd3, 32'd9, 31'd4);
        add_item(OP_DIV, 32'd3, 31'd7, 32'hffff_fffb, 31'd14);
        add_item(OP_DIV, 32'd5, 31'd3, 32'd0, 31'd7);
        add_item(OP_ADD, 32'd5, 31'd0, 32'd1, 31'd2);
        add_item(OP_MUL, 32'd5, 31'd3, 32'd1, 31'd0);
        add_item(OP_ADD, 32'h7fff_ffff, 31'd1, 32'd1, 31'd1);
        add_item(OP_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
        add_item(OP_MUL, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
        add_item(OP_DIV, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        add_item(OP_DIV, 32'd1, 31'd1, 32'h8000_0000, 31'd3);
        add_item(OP_ADD, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_fffe);
        add_item(OP_MUL, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        add_item(OP_SUB, 32'd0, 31'd5, 32'd0, 31'd9);
        add_item(OP_ADD, 32'hffff_ffff, 31'h5555_5555, 32'h8000_0000, 31'h2aaa_aaaa);
        add_item(OP_MUL, 32'd65536, 31'd1, 32'd65536, 31'd1);
        add_item(OP_DIV, 32'd6, 31'd35, 32'd10, 31'd21);
        add_item(OP_SUB, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        repeat (640) begin
            op = 2'($urandom_range(0, 3));
            add_item(op, pick_num(), pick_den(), pick_num(), pick_den());
        end
        stim_done = 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= '0;
            s_axis_tuser <= OP_ADD;
            send_gap <= 0;
            n_sent <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                result_q.push_back(predict_fraction('{opcode: s_axis_tuser,
                                                      a_num: s_axis_tdata[31:0],
                                                      a_den: s_axis_tdata[62:32],
                                                      b_num: s_axis_tdata[94:63],
                                                      b_den: s_axis_tdata[125:95]}));
                n_sent <= n_sent + 1;
            end
            if (send_gap > 0 || pending_q.size() == 0) begin
                s_axis_tvalid <= 0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                t_frac_req r;
                r = pending_q.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tuser <= r.opcode;
                s_axis_tdata <= {2'b00, r.b_den, r.b_num, r.a_den, r.a_num};
                send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            recv_gap <= 0;
            hold_cycles <= 0;
            n_recv <= 0;
            n_err <= 0;
            n_ovf <= 0;
            n_zero <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_frac_res got;
                t_frac_res want;
                got = {m_axis_tdata[31:0], m_axis_tdata[62:32], m_axis_tuser};
                n_recv <= n_recv + 1;
                if (m_axis_tuser == ST_OVF) n_ovf <= n_ovf + 1;
                if (m_axis_tuser == ST_ZERO) n_zero <= n_zero + 1;
                if (result_q.size() == 0) begin
                    n_err <= n_err + 1;
                    if (n_err < 10) $display("Unexpected result %h", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want || m_axis_tdata[63] !== 1'b0) begin
                        n_err <= n_err + 1;
                        if (n_err < 10)
                            $display("Mismatch: num %h/%h den %h/%h status %0d/%0d",
                                     got.res_num, want.res_num, got.res_den,
                                     want.res_den, got.status, want.status);
                    end
                end
            end
            // One long hold-off early on lets the sender back up against a busy block.
            if (n_recv == 30 && hold_cycles == 0) begin
                hold_cycles <= 3000;
                m_axis_tready <= 0;
            end else if (hold_cycles > 1) begin
                hold_cycles <= hold_cycles - 1;
                m_axis_tready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 0;
                if (hold_cycles == 1) hold_cycles <= -1;
            end else begin
                if (hold_cycles == 1) hold_cycles <= -1;
                m_axis_tready <= 1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (pending_q.size() == 0 && !s_axis_tvalid);
        wait (result_q.size() == 0);
        repeat (2000) @(posedge i_clk);
        $display("Ran %0d fraction operations, %0d results, %0d overflow, %0d zero-den.",
                 n_sent, n_recv, n_ovf, n_zero);
        if (n_err == 0 && result_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_err);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
